[hdl/cma_pkg.sv]
// Shared constants and the sequencer state type of the centred moving average.
package cma_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_RADIUS  = 31;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed widths of the radius register and of the per-block counters.
    localparam int RADIUS_W     = 5;
    localparam int COUNT_W      = 16;
    localparam int RADIUS_RESET = 1;

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PEND  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } seq_state_t;

endpackage

[hdl/cma_store.sv]
// Sample window memory: one write port, one read port with registered data.
module cma_store #(
    parameter int DEPTH  = 2 * cma_pkg::DEF_MAX_RADIUS + 1,
    parameter int DATA_W = cma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/cma_div.sv]
// Restoring divider: signed sum by unsigned count, one quotient bit per cycle,
// quotient truncated toward zero.
module cma_div #(
    parameter int SUM_W = 22,
    parameter int DIV_W = 6,
    parameter int Q_W   = cma_pkg::DEF_SAMPLE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic              neg_reg,   neg_next;
    logic [SUM_W-1:0]  dvd_reg,   dvd_next;
    logic [DIV_W:0]    rem_reg,   rem_next;
    logic [DIV_W-1:0]  dsr_reg,   dsr_next;

    logic [DIV_W:0]    shifted;
    logic              qbit;
    logic [SUM_W-1:0]  mag_in;
    logic [SUM_W-1:0]  signed_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign mag_in  = dividend[SUM_W-1] ? (SUM_W'(~dividend) + SUM_W'(1)) : dividend;
    assign shifted = {rem_reg[DIV_W-1:0], dvd_reg[SUM_W-1]};
    assign qbit    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            neg_next  = dividend[SUM_W-1];
            dvd_next  = mag_in;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits its lower bits.
            rem_next  = qbit ? (shifted - {1'b0, dsr_reg}) : shifted;
            dvd_next  = {dvd_reg[SUM_W-2:0], qbit};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign signed_q = neg_reg ? (SUM_W'(~dvd_reg) + SUM_W'(1)) : dvd_reg;
    assign quotient = signed_q[Q_W-1:0];
    assign done     = done_reg;

endmodule

[hdl/centered_moving_average.sv]
// Top level: sequencer, window summation and output register of the moving average.
//
//  Channel   Signals                              Contents (lowest bit first)
//  input     s_tvalid s_tready s_tdata s_tlast    sample | block end on tlast
//  output    m_tvalid m_tready m_tdata m_tlast    average | last of block on tlast
//  config    cfg_we cfg_wdata                     radius (5 bits)
//
// Each sample passes through bookkeeping states (the accepting state, the pending count
// and the final check), and each result it releases passes through a check, the
// summation of the window through the single memory read port, the shared divider
// and the load of the output register.
// s_tready is high only while the sequencer is idle. A result waiting on m_tready
// stalls the sequencer only when the next result is ready to be loaded.
// Reset is asynchronous; the memory needs no clearing pass, as an entry is only
// read after it has been written in the current block.
module centered_moving_average #(
    parameter int MAX_RADIUS  = cma_pkg::DEF_MAX_RADIUS,
    parameter int SAMPLE_BITS = cma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,  // average
    output logic                                   m_tlast,
    input  logic                                   cfg_we,
    input  logic [cma_pkg::RADIUS_W-1:0]           cfg_wdata
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int T_W    = $clog2(DEPTH + 1);
    localparam int R_W    = $clog2(MAX_RADIUS + 1);
    localparam int P_W    = $clog2(MAX_RADIUS + 2);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH);
    localparam int CNT_W  = cma_pkg::COUNT_W;
    localparam int RAD_W  = cma_pkg::RADIUS_W;
    localparam int EXT_W  = (R_W > RAD_W) ? R_W : RAD_W;

    cma_pkg::seq_state_t state_reg, state_next;

    logic [RAD_W-1:0]       radius_reg,     radius_next;
    logic [PTR_W-1:0]       wr_ptr_reg,     wr_ptr_next;
    logic [PTR_W-1:0]       newest_reg,     newest_next;
    logic [CNT_W-1:0]       seen_reg,       seen_next;
    logic [CNT_W-1:0]       sent_reg,       sent_next;
    logic [CNT_W-1:0]       latest_reg,     latest_next;
    logic                   long_reg,       long_next;
    logic                   end_reg,        end_next;
    logic [P_W-1:0]         pending_reg,    pending_next;
    logic [T_W-1:0]         t_reg,          t_next;
    logic [T_W-1:0]         tend_reg,       tend_next;
    logic [T_W-1:0]         count_reg,      count_next;
    logic                   rd_valid_reg,   rd_valid_next;
    logic signed [SUM_W-1:0] acc_reg,       acc_next;
    logic                   m_valid_reg,    m_valid_next;
    logic [SAMPLE_BITS-1:0] m_data_reg,     m_data_next;
    logic                   m_last_reg,     m_last_next;

    logic                   s_accept;
    logic [EXT_W-1:0]       radius_ext;
    logic [R_W-1:0]         r_eff;
    logic [CNT_W-1:0]       r16;
    logic [CNT_W-1:0]       diff;
    logic [P_W-1:0]         back;
    logic [CNT_W-1:0]       back16;
    logic [CNT_W-1:0]       k;
    logic [R_W-1:0]         right_n;
    logic [R_W-1:0]         left_n;
    logic                   issue;
    logic [T_W:0]           pos_wide;
    logic [PTR_W-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   sum_done;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] quotient;
    logic                   slot_free;

    cma_store #(
        .DEPTH  (DEPTH),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (s_accept),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cma_div #(
        .SUM_W (SUM_W),
        .DIV_W (T_W),
        .Q_W   (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sum_done),
        .dividend (acc_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cma_pkg::ST_IDLE;
            radius_reg   <= RAD_W'(cma_pkg::RADIUS_RESET);
            wr_ptr_reg   <= '0;
            seen_reg     <= '0;
            sent_reg     <= '0;
            long_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            radius_reg   <= radius_next;
            wr_ptr_reg   <= wr_ptr_next;
            seen_reg     <= seen_next;
            sent_reg     <= sent_next;
            long_reg     <= long_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg  <= newest_next;
        latest_reg  <= latest_next;
        end_reg     <= end_next;
        pending_reg <= pending_next;
        t_reg       <= t_next;
        tend_reg    <= tend_next;
        count_reg   <= count_next;
        acc_reg     <= acc_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign s_tready  = (state_reg == cma_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign radius_next = cfg_we ? cfg_wdata : radius_reg;

    // Radius zero counts as one; anything above the store's reach is clipped.
    assign radius_ext = EXT_W'(radius_reg);
    always_comb
    begin
        if (radius_ext == '0)
        begin
            r_eff = R_W'(1);
        end
        else if (radius_ext > EXT_W'(MAX_RADIUS))
        begin
            r_eff = R_W'(MAX_RADIUS);
        end
        else
        begin
            r_eff = R_W'(radius_ext);
        end
    end

    assign r16    = CNT_W'(r_eff);
    assign diff   = seen_reg - sent_reg;
    assign back   = pending_reg - P_W'(1);
    assign back16 = CNT_W'(back);
    assign k      = latest_reg - back16;
    assign right_n = (back16 < r16) ? R_W'(back) : r_eff;
    assign left_n  = (!long_reg && (k < r16)) ? R_W'(k) : r_eff;

    // Window entry t samples before the newest one, modulo the store depth.
    assign issue    = (state_reg == cma_pkg::ST_SUM) && (t_reg <= tend_reg);
    assign pos_wide = ((T_W + 1)'(newest_reg) >= (T_W + 1)'(t_reg))
                    ? ((T_W + 1)'(newest_reg) - (T_W + 1)'(t_reg))
                    : ((T_W + 1)'(newest_reg) + (T_W + 1)'(DEPTH) - (T_W + 1)'(t_reg));
    assign rd_addr  = pos_wide[PTR_W-1:0];
    assign sum_done = (state_reg == cma_pkg::ST_SUM) && !issue && !rd_valid_reg;

    assign slot_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        newest_next   = newest_reg;
        seen_next     = seen_reg;
        sent_next     = sent_reg;
        latest_next   = latest_reg;
        long_next     = long_reg;
        end_next      = end_reg;
        pending_next  = pending_reg;
        t_next        = t_reg;
        tend_next     = tend_reg;
        count_next    = count_reg;
        rd_valid_next = issue;
        acc_next      = acc_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;

        case (state_reg)
            cma_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    newest_next = wr_ptr_reg;
                    wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1))
                                ? '0 : (wr_ptr_reg + PTR_W'(1));
                    latest_next = seen_reg;
                    seen_next   = seen_reg + CNT_W'(1);
                    if (seen_reg == '1)
                    begin
                        long_next = 1'b1;
                    end
                    end_next   = s_tlast;
                    state_next = cma_pkg::ST_PEND;
                end
            end

            cma_pkg::ST_PEND:
            begin
                pending_next = (diff > CNT_W'(MAX_RADIUS + 1))
                             ? P_W'(MAX_RADIUS + 1) : P_W'(diff);
                state_next   = cma_pkg::ST_CHECK;
            end

            cma_pkg::ST_CHECK:
            begin
                // Results wait until the sample radius places later has arrived,
                // unless the block ends here.
                if ((pending_reg == '0) || (!end_reg && (back16 < r16)))
                begin
                    if (end_reg)
                    begin
                        seen_next = '0;
                        sent_next = '0;
                        long_next = 1'b0;
                    end
                    state_next = cma_pkg::ST_IDLE;
                end
                else
                begin
                    t_next     = T_W'(back) - T_W'(right_n);
                    tend_next  = T_W'(back) + T_W'(left_n);
                    count_next = T_W'(left_n) + T_W'(right_n) + T_W'(1);
                    acc_next   = '0;
                    state_next = cma_pkg::ST_SUM;
                end
            end

            cma_pkg::ST_SUM:
            begin
                if (issue)
                begin
                    t_next = t_reg + T_W'(1);
                end
                if (rd_valid_reg)
                begin
                    acc_next = acc_reg + SUM_W'(signed'(rd_data));
                end
                if (sum_done)
                begin
                    state_next = cma_pkg::ST_DIV;
                end
            end

            cma_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = cma_pkg::ST_EMIT;
                end
            end

            cma_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = quotient;
                    m_last_next  = end_reg && (pending_reg == P_W'(1));
                    pending_next = pending_reg - P_W'(1);
                    sent_next    = sent_reg + CNT_W'(1);
                    state_next   = cma_pkg::ST_CHECK;
                end
            end

            default:
            begin
                state_next = cma_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(m_data_reg);
    assign m_tlast  = m_last_reg;

endmodule
